[rtl/rcp_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// rcp_pkg
// Shared constants, codes and types of the raster crop and pad window unit.
// ---------------------------------------------------------------------------
package rcp_pkg;

  localparam int OUT_COLS    = 512;
  localparam int FULL_ROWS   = 512;
  localparam int HALF_ROWS   = 256;
  localparam int MAX_SRC_DIM = 4096;

  localparam int GREY_W  = 8;
  localparam int ROW_W   = 9;
  localparam int COL_W   = 9;
  localparam int SPAN_W  = 10;
  localparam int OFS_W   = 12;
  localparam int DIM_W   = 13;
  localparam int MODE_W  = 2;
  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 3;

  // arithmetic width for offsets, limits and positions
  localparam int AW = 14;

  localparam logic [AW-1:0]     COLS_A     = AW'(OUT_COLS);
  localparam logic [AW-1:0]     HALF_A     = AW'(HALF_ROWS);
  localparam logic [SPAN_W-1:0] ROWS_FULL_S = SPAN_W'(FULL_ROWS);
  localparam logic [SPAN_W-1:0] ROWS_HALF_S = SPAN_W'(HALF_ROWS);
  localparam logic [SPAN_W-1:0] COLS_S      = SPAN_W'(OUT_COLS);

  localparam int MAX_RES  = 4;
  localparam int RQ_DEPTH = 8;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_COL  = 3'd0,
    CFG_START_ROW  = 3'd1,
    CFG_FILL_VALUE = 3'd2,
    CFG_ROW_MODE   = 3'd3,
    CFG_TOP_FIRST  = 3'd4,
    CFG_SRC_WIDTH  = 3'd5,
    CFG_SRC_HEIGHT = 3'd6
  } cfg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    ROW_AUTO = 2'd0,
    ROW_HALF = 2'd1,
    ROW_FULL = 2'd2
  } row_mode_t;

  typedef struct packed {
    logic [ROW_W-1:0]  out_row;
    logic [SPAN_W-1:0] row_span;
    logic [COL_W-1:0]  out_col;
    logic [SPAN_W-1:0] col_span;
    logic [GREY_W-1:0] grey;
    logic              last;
  } rcp_res_t;

endpackage
`default_nettype wire

[rtl/rcp_pix_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// rcp_pix_if
// Source pixel channel: valid/ready handshake with one grey value.
// ---------------------------------------------------------------------------
interface rcp_pix_if;
  logic                      valid;
  logic                      ready;
  logic [rcp_pkg::GREY_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface
`default_nettype wire

[rtl/rcp_res_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// rcp_res_if
// Rectangle write channel: valid/ready handshake with one rectangle.
// ---------------------------------------------------------------------------
interface rcp_res_if;
  logic                       valid;
  logic                       ready;
  logic [rcp_pkg::ROW_W-1:0]  out_row;
  logic [rcp_pkg::SPAN_W-1:0] row_span;
  logic [rcp_pkg::COL_W-1:0]  out_col;
  logic [rcp_pkg::SPAN_W-1:0] col_span;
  logic [rcp_pkg::GREY_W-1:0] grey;
  logic                       last;

  modport source (output valid, output out_row, output row_span, output out_col,
                  output col_span, output grey, output last, input ready);
  modport sink   (input valid, input out_row, input row_span, input out_col,
                  input col_span, input grey, input last, output ready);
endinterface
`default_nettype wire

[rtl/raster_crop_pad_window_unit.sv]
// A pixel accepted on in_ch sits in the input register until it is mapped, and
// its rectangles are then written to the result queue and offered on out_ch.
// Throughput: one pixel per cycle; each pixel yields zero to four rectangles
// that drain through an 8-entry result queue at one per cycle while out_ch is
// ready, and a pixel is mapped only while the queue has four free entries.
// Reset (rst_n low, synchronous): queue empty, no frame open, registers to defaults.
`default_nettype none
// ---------------------------------------------------------------------------
// raster_crop_pad_window_unit
// Maps a raster pixel stream into a fixed output frame as rectangle writes:
// single pixels, row-end background fills and frame background fills.
// ---------------------------------------------------------------------------
module raster_crop_pad_window_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  rcp_pix_if.sink                            in_ch,
  rcp_res_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [rcp_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [rcp_pkg::CFG_W-1:0]     cfg_data
);

  localparam int AW = rcp_pkg::AW;

  // configuration registers
  logic [rcp_pkg::OFS_W-1:0]  start_col_r, start_row_r;
  logic [rcp_pkg::GREY_W-1:0] fill_value_r;
  logic [rcp_pkg::MODE_W-1:0] row_mode_r;
  logic                       top_first_r;
  logic [rcp_pkg::DIM_W-1:0]  src_width_r, src_height_r;

  // geometry latched at frame start
  logic [rcp_pkg::OFS_W-1:0]  f_sc_r, f_sr_r;
  logic [rcp_pkg::GREY_W-1:0] f_fill_r;
  logic                       f_top_r, f_full_r;
  logic [rcp_pkg::DIM_W-1:0]  f_w_r, f_h_r;

  // frame state
  logic                       frame_open_r, frame_open_nxt;
  logic [rcp_pkg::DIM_W-1:0]  col_pos_r, col_pos_nxt;
  logic [rcp_pkg::DIM_W-1:0]  row_pos_r, row_pos_nxt;
  logic [rcp_pkg::SPAN_W-1:0] rows_done_r, rows_done_nxt;

  // input register
  logic                       stg_vld_r;
  logic [rcp_pkg::GREY_W-1:0] stg_pix_r;

  // result queue
  rcp_pkg::rcp_res_t          rq_mem [rcp_pkg::RQ_DEPTH];
  logic [rcp_pkg::RQ_AW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r;
  logic [rcp_pkg::RQ_CW-1:0]  cnt_r, cnt_nxt;

  logic proc, pop;

  logic [rcp_pkg::OFS_W-1:0]  e_sc, e_sr;
  logic [rcp_pkg::GREY_W-1:0] e_fill;
  logic                       e_top, e_full, live_full;
  logic [rcp_pkg::DIM_W-1:0]  e_w, e_h, live_w, live_h;
  logic [rcp_pkg::SPAN_W-1:0] e_rows;
  logic [rcp_pkg::DIM_W-1:0]  rpos, cpos;
  logic [AW-1:0]              e_end, sc_lim, rpos_a, cpos_a, nx, c0, sc_a;
  logic [AW-1:0]              row_off, lead_diff, col_pix, col_fill, span_fill;
  logic                       inwin, lead_ok, pix_ok, row_end, fill_ok, lastrow, end_ok;
  logic [rcp_pkg::SPAN_W-1:0] lead_span, rd_base, rd_row, rem;

  rcp_pkg::rcp_res_t                slot_res [rcp_pkg::MAX_RES];
  logic [rcp_pkg::MAX_RES-1:0]      slot_v;
  logic [rcp_pkg::RQ_AW-1:0]        slot_ptr [rcp_pkg::MAX_RES];
  logic [rcp_pkg::RQ_CW-1:0]        nres;

  assign pop          = out_ch.valid && out_ch.ready;
  assign proc         = stg_vld_r && (cnt_r <= rcp_pkg::RQ_CW'(rcp_pkg::RQ_DEPTH
                                                             - rcp_pkg::MAX_RES));
  assign in_ch.ready  = !stg_vld_r || proc;

  // effective geometry: live registers at frame start, latched copy inside a frame
  always_comb begin
    live_w = (src_width_r == '0) ? rcp_pkg::DIM_W'(1) : src_width_r;
    live_h = (src_height_r == '0) ? rcp_pkg::DIM_W'(1) : src_height_r;
    case (rcp_pkg::row_mode_t'(row_mode_r))
      rcp_pkg::ROW_HALF: live_full = 1'b0;
      rcp_pkg::ROW_FULL: live_full = 1'b1;
      default:           live_full = (AW'(start_row_r) + rcp_pkg::HALF_A) < AW'(live_h);
    endcase
    if (frame_open_r) begin
      e_sc = f_sc_r;   e_sr = f_sr_r;   e_fill = f_fill_r; e_top = f_top_r;
      e_w  = f_w_r;    e_h  = f_h_r;    e_full = f_full_r;
    end else begin
      e_sc = start_col_r; e_sr = start_row_r; e_fill = fill_value_r; e_top = top_first_r;
      e_w  = live_w;      e_h  = live_h;      e_full = live_full;
    end
  end

  // mapping of the current pixel
  always_comb begin
    e_rows  = e_full ? rcp_pkg::ROWS_FULL_S : rcp_pkg::ROWS_HALF_S;
    e_end   = AW'(e_sr) + AW'(e_rows);
    sc_a    = AW'(e_sc);
    sc_lim  = sc_a + rcp_pkg::COLS_A;
    rpos    = frame_open_r ? row_pos_r : (e_top ? '0 : e_h - rcp_pkg::DIM_W'(1));
    cpos    = frame_open_r ? col_pos_r : '0;
    rpos_a  = AW'(rpos);
    cpos_a  = AW'(cpos);
    inwin   = (rpos_a >= AW'(e_sr)) && (rpos_a < e_end);
    lead_ok = !frame_open_r && !e_top && inwin && ((rpos_a + AW'(1)) < e_end);
    lead_diff = e_end - rpos_a - AW'(1);
    lead_span = lead_diff[rcp_pkg::SPAN_W-1:0];
    rd_base = frame_open_r ? rows_done_r : (lead_ok ? lead_span : '0);
    pix_ok  = inwin && (cpos_a >= sc_a) && (cpos_a < sc_lim);
    nx      = cpos_a + AW'(1);
    row_end = nx >= AW'(e_w);
    fill_ok = row_end && inwin && (nx < sc_lim);
    c0      = (nx > sc_a) ? nx : sc_a;
    rd_row  = rd_base + rcp_pkg::SPAN_W'(row_end && inwin);
    lastrow = row_end && (e_top ? ((rpos_a + AW'(1)) >= AW'(e_h)) : (rpos == '0));
    end_ok  = lastrow && (rd_row < e_rows);
    rem     = e_rows - rd_row;
    row_off = rpos_a - AW'(e_sr);
    col_pix = cpos_a - sc_a;
    col_fill  = c0 - sc_a;
    span_fill = sc_lim - c0;

    slot_v = {end_ok, fill_ok, pix_ok, lead_ok};

    slot_res[0].out_row  = row_off[rcp_pkg::ROW_W-1:0] + rcp_pkg::ROW_W'(1);
    slot_res[0].row_span = lead_span;
    slot_res[0].out_col  = '0;
    slot_res[0].col_span = rcp_pkg::COLS_S;
    slot_res[0].grey     = e_fill;
    slot_res[0].last     = lead_ok && !pix_ok && !fill_ok && !end_ok;

    slot_res[1].out_row  = row_off[rcp_pkg::ROW_W-1:0];
    slot_res[1].row_span = rcp_pkg::SPAN_W'(1);
    slot_res[1].out_col  = col_pix[rcp_pkg::COL_W-1:0];
    slot_res[1].col_span = rcp_pkg::SPAN_W'(1);
    slot_res[1].grey     = stg_pix_r;
    slot_res[1].last     = !fill_ok && !end_ok;

    slot_res[2].out_row  = row_off[rcp_pkg::ROW_W-1:0];
    slot_res[2].row_span = rcp_pkg::SPAN_W'(1);
    slot_res[2].out_col  = col_fill[rcp_pkg::COL_W-1:0];
    slot_res[2].col_span = span_fill[rcp_pkg::SPAN_W-1:0];
    slot_res[2].grey     = e_fill;
    slot_res[2].last     = !end_ok;

    slot_res[3].out_row  = e_top ? rd_row[rcp_pkg::ROW_W-1:0] : '0;
    slot_res[3].row_span = rem;
    slot_res[3].out_col  = '0;
    slot_res[3].col_span = rcp_pkg::COLS_S;
    slot_res[3].grey     = e_fill;
    slot_res[3].last     = 1'b1;
  end

  // pack valid rectangles into consecutive queue entries
  always_comb begin
    nres = '0;
    for (int i = 0; i < rcp_pkg::MAX_RES; i++) begin
      slot_ptr[i] = wr_ptr_r + nres[rcp_pkg::RQ_AW-1:0];
      nres        = nres + rcp_pkg::RQ_CW'(slot_v[i]);
    end
    wr_ptr_nxt = proc ? wr_ptr_r + nres[rcp_pkg::RQ_AW-1:0] : wr_ptr_r;
    cnt_nxt    = cnt_r - rcp_pkg::RQ_CW'(pop) + (proc ? nres : '0);
  end

  always_comb begin
    frame_open_nxt = !lastrow;
    rows_done_nxt  = rd_row;
    col_pos_nxt    = row_end ? '0 : nx[rcp_pkg::DIM_W-1:0];
    if (row_end && !lastrow) begin
      row_pos_nxt = e_top ? rpos + rcp_pkg::DIM_W'(1) : rpos - rcp_pkg::DIM_W'(1);
    end else begin
      row_pos_nxt = rpos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_col_r  <= '0;
      start_row_r  <= '0;
      fill_value_r <= '0;
      row_mode_r   <= rcp_pkg::ROW_AUTO;
      top_first_r  <= 1'b1;
      src_width_r  <= rcp_pkg::DIM_W'(512);
      src_height_r <= rcp_pkg::DIM_W'(512);
    end else if (cfg_we) begin
      case (rcp_pkg::cfg_idx_t'(cfg_idx))
        rcp_pkg::CFG_START_COL:  start_col_r  <= cfg_data[rcp_pkg::OFS_W-1:0];
        rcp_pkg::CFG_START_ROW:  start_row_r  <= cfg_data[rcp_pkg::OFS_W-1:0];
        rcp_pkg::CFG_FILL_VALUE: fill_value_r <= cfg_data[rcp_pkg::GREY_W-1:0];
        rcp_pkg::CFG_ROW_MODE:   row_mode_r   <= cfg_data[rcp_pkg::MODE_W-1:0];
        rcp_pkg::CFG_TOP_FIRST:  top_first_r  <= cfg_data[0];
        rcp_pkg::CFG_SRC_WIDTH:  src_width_r  <= cfg_data[rcp_pkg::DIM_W-1:0];
        rcp_pkg::CFG_SRC_HEIGHT: src_height_r <= cfg_data[rcp_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      col_pos_r    <= '0;
      row_pos_r    <= '0;
      rows_done_r  <= '0;
      stg_vld_r    <= 1'b0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      cnt_r        <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        stg_vld_r <= 1'b1;
      end else if (proc) begin
        stg_vld_r <= 1'b0;
      end
      if (proc) begin
        frame_open_r <= frame_open_nxt;
        col_pos_r    <= col_pos_nxt;
        row_pos_r    <= row_pos_nxt;
        rows_done_r  <= rows_done_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + rcp_pkg::RQ_AW'(1);
      end
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stg_pix_r <= in_ch.pixel;
    end
    if (proc && !frame_open_r) begin
      f_sc_r   <= start_col_r;
      f_sr_r   <= start_row_r;
      f_fill_r <= fill_value_r;
      f_top_r  <= top_first_r;
      f_w_r    <= live_w;
      f_h_r    <= live_h;
      f_full_r <= live_full;
    end
    for (int i = 0; i < rcp_pkg::MAX_RES; i++) begin
      if (proc && slot_v[i]) begin
        rq_mem[slot_ptr[i]] <= slot_res[i];
      end
    end
  end

  assign out_ch.valid    = (cnt_r != '0);
  assign out_ch.out_row  = rq_mem[rd_ptr_r].out_row;
  assign out_ch.row_span = rq_mem[rd_ptr_r].row_span;
  assign out_ch.out_col  = rq_mem[rd_ptr_r].out_col;
  assign out_ch.col_span = rq_mem[rd_ptr_r].col_span;
  assign out_ch.grey     = rq_mem[rd_ptr_r].grey;
  assign out_ch.last     = rq_mem[rd_ptr_r].last;

endmodule
`default_nettype wire

[rtl/rcp_port_checker.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// rcp_port_checker
// Port-level checks of the rectangle channel of the crop and pad window unit.
// ---------------------------------------------------------------------------
module rcp_port_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [rcp_pkg::ROW_W-1:0]  out_row,
  input wire logic [rcp_pkg::SPAN_W-1:0] row_span,
  input wire logic [rcp_pkg::COL_W-1:0]  out_col,
  input wire logic [rcp_pkg::SPAN_W-1:0] col_span,
  input wire logic [rcp_pkg::GREY_W-1:0] grey,
  input wire logic                       last
);

  localparam int SW = rcp_pkg::SPAN_W + 1;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  a_rows_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (row_span != '0)
                  && ((SW'(out_row) + SW'(row_span)) <= SW'(rcp_pkg::FULL_ROWS)))
    else $error("rectangle rows leave the frame");

  a_cols_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (col_span != '0)
                  && ((SW'(out_col) + SW'(col_span)) <= SW'(rcp_pkg::OUT_COLS)))
    else $error("rectangle columns leave the frame");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable({out_row, row_span, out_col, col_span, grey, last}))
    else $error("stalled transaction changed");

endmodule

bind raster_crop_pad_window_unit rcp_port_checker u_rcp_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_row   (out_ch.out_row),
  .row_span  (out_ch.row_span),
  .out_col   (out_ch.out_col),
  .col_span  (out_ch.col_span),
  .grey      (out_ch.grey),
  .last      (out_ch.last)
);
`default_nettype wire

[tb/rcp_window_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rcp_window_checker
// Watches the register port and both channels of the crop and pad window
// unit. Keeps its own copy of the registers and of the frame position,
// predicts the rectangle writes of every accepted pixel, and compares each
// accepted rectangle field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module rcp_window_checker
  import rcp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  rcp_pix_if                        pix,
  rcp_res_if                        rect,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output int                        rects_pending,
  output int                        mismatches
);

  // register shadow
  int                cfg_sc, cfg_sr, cfg_w, cfg_h;
  logic [GREY_W-1:0] cfg_fill;
  logic [MODE_W-1:0] cfg_mode;
  logic              cfg_top;

  // geometry latched at frame start, and position in the frame
  bit                frm_open;
  int                frm_sc, frm_sr, frm_rows, frm_end, frm_w, frm_h;
  logic [GREY_W-1:0] frm_fill;
  logic              frm_top;
  int                col_pos, row_pos, rows_done;

  rcp_res_t pending_rects[$];
  rcp_res_t want;

  function automatic void add_rect(int row, int rspan, int col, int cspan,
                                   logic [GREY_W-1:0] g);
    rcp_res_t r;
    r.out_row  = ROW_W'(row);
    r.row_span = SPAN_W'(rspan);
    r.out_col  = COL_W'(col);
    r.col_span = SPAN_W'(cspan);
    r.grey     = g;
    r.last     = 1'b0;
    pending_rects.push_back(r);
  endfunction

  function automatic bit row_in_frame(int r);
    return r >= frm_sr && r < frm_end;
  endfunction

  task automatic map_pixel(input logic [GREY_W-1:0] pix_val);
    int  first_new;
    int  lead, x, nx, c0;
    bit  in_win, last_row;
    first_new = pending_rects.size();
    if (!frm_open) begin
      frm_sc   = cfg_sc;
      frm_sr   = cfg_sr;
      frm_fill = cfg_fill;
      frm_top  = cfg_top;
      frm_w    = (cfg_w == 0) ? 1 : cfg_w;
      frm_h    = (cfg_h == 0) ? 1 : cfg_h;
      if (cfg_mode == ROW_HALF) begin
        frm_rows = HALF_ROWS;
      end else if (cfg_mode == ROW_FULL) begin
        frm_rows = FULL_ROWS;
      end else begin
        frm_rows = (frm_sr + HALF_ROWS < frm_h) ? FULL_ROWS : HALF_ROWS;
      end
      frm_end   = frm_sr + frm_rows;
      row_pos   = frm_top ? 0 : frm_h - 1;
      col_pos   = 0;
      rows_done = 0;
      frm_open  = 1'b1;
      if (!frm_top && row_in_frame(row_pos)) begin
        lead = frm_end - row_pos - 1;
        if (lead > 0) begin
          add_rect(row_pos - frm_sr + 1, lead, 0, OUT_COLS, frm_fill);
          rows_done += lead;
        end
      end
    end

    in_win = row_in_frame(row_pos);
    x      = col_pos;
    if (in_win && x >= frm_sc && x < frm_sc + OUT_COLS) begin
      add_rect(row_pos - frm_sr, 1, x - frm_sc, 1, pix_val);
    end

    nx = x + 1;
    if (nx >= frm_w) begin
      // row end: pad the columns the source row does not reach
      if (in_win && nx < frm_sc + OUT_COLS) begin
        c0 = (nx > frm_sc) ? nx : frm_sc;
        add_rect(row_pos - frm_sr, 1, c0 - frm_sc, frm_sc + OUT_COLS - c0, frm_fill);
      end
      if (in_win) begin
        rows_done++;
      end
      col_pos  = 0;
      last_row = frm_top ? (row_pos + 1 >= frm_h) : (row_pos <= 0);
      if (last_row) begin
        if (rows_done < frm_rows) begin
          add_rect(frm_top ? rows_done : 0, frm_rows - rows_done, 0, OUT_COLS, frm_fill);
          rows_done = frm_rows;
        end
        frm_open = 1'b0;
      end else begin
        row_pos += frm_top ? 1 : -1;
      end
    end else begin
      col_pos = nx;
    end

    if (pending_rects.size() > first_new) begin
      pending_rects[pending_rects.size() - 1].last = 1'b1;
    end
  endtask

  task automatic cmp_field(string what, int exp_val, int act_val);
    if (exp_val != act_val) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_val,
               act_val);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_sc     = 0;
      cfg_sr     = 0;
      cfg_fill   = '0;
      cfg_mode   = ROW_AUTO;
      cfg_top    = 1'b1;
      cfg_w      = 512;
      cfg_h      = 512;
      frm_open   = 1'b0;
      col_pos    = 0;
      row_pos    = 0;
      rows_done  = 0;
      mismatches = 0;
      pending_rects.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_idx))
          CFG_START_COL:  cfg_sc   = int'(cfg_data[OFS_W-1:0]);
          CFG_START_ROW:  cfg_sr   = int'(cfg_data[OFS_W-1:0]);
          CFG_FILL_VALUE: cfg_fill = cfg_data[GREY_W-1:0];
          CFG_ROW_MODE:   cfg_mode = cfg_data[MODE_W-1:0];
          CFG_TOP_FIRST:  cfg_top  = cfg_data[0];
          CFG_SRC_WIDTH:  cfg_w    = int'(cfg_data[DIM_W-1:0]);
          CFG_SRC_HEIGHT: cfg_h    = int'(cfg_data[DIM_W-1:0]);
          default: ;
        endcase
      end
      if (pix.valid && pix.ready) begin
        map_pixel(pix.pixel);
      end
      if (rect.valid && rect.ready) begin
        if (pending_rects.size() == 0) begin
          mismatches++;
          $display({"%0t: rectangle mismatch, expected none, ",
                    "actual row %0d+%0d col %0d+%0d grey %0d"},
                   $time, rect.out_row, rect.row_span, rect.out_col, rect.col_span,
                   rect.grey);
        end else begin
          want = pending_rects.pop_front();
          cmp_field("out_row", want.out_row, rect.out_row);
          cmp_field("row_span", want.row_span, rect.row_span);
          cmp_field("out_col", want.out_col, rect.out_col);
          cmp_field("col_span", want.col_span, rect.col_span);
          cmp_field("grey", want.grey, rect.grey);
          cmp_field("last", want.last, rect.last);
        end
      end
    end
    rects_pending = pending_rects.size();
  end

endmodule

[tb/tb_raster_crop_pad_window_unit.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_raster_crop_pad_window_unit
// Drives whole source frames into the crop and pad window unit under a range
// of register settings: a few small directed frames, frames at the offset
// extremes, then random small frames. Both channels idle in random
// bursts; the checker beside the block predicts and compares every rectangle.
// ---------------------------------------------------------------------------
module tb_raster_crop_pad_window_unit;
  import rcp_pkg::*;

  localparam logic [MODE_W-1:0] ROW_SPARE = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  int  rects_pending;
  int  mismatches;
  bit  src_gaps;
  bit  sink_stalls;
  int  sink_hold = 0;
  int  pixels_sent;

  logic [GREY_W-1:0] ramp[4] = '{8'h00, 8'hFF, 8'h55, 8'hAA};

  rcp_pix_if pix_ch();
  rcp_res_if rect_ch();

  raster_crop_pad_window_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (pix_ch),
    .out_ch   (rect_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  rcp_window_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .pix           (pix_ch),
    .rect          (rect_ch),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_data      (cfg_data),
    .rects_pending (rects_pending),
    .mismatches    (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // result side: stall in random bursts
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      rect_ch.ready <= 1'b0;
      sink_hold     <= sink_hold - 1;
    end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
      rect_ch.ready <= 1'b0;
      sink_hold     <= $urandom_range(0, 3);
    end else begin
      rect_ch.ready <= 1'b1;
    end
  end

  task automatic wait_idle();
    while (rects_pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  function automatic int pick_offset();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 4);
  endfunction

  task automatic run_frame(int sc, int sr, int fill, int mode, int top, int w, int h,
                           bit patterned);
    cfg_idx_t regs[7];
    int       vals[7];
    int       n;
    regs = '{CFG_START_COL, CFG_START_ROW, CFG_FILL_VALUE, CFG_ROW_MODE,
             CFG_TOP_FIRST, CFG_SRC_WIDTH, CFG_SRC_HEIGHT};
    vals = '{sc, sr, fill, mode, top, w, h};
    n    = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);

    wait_idle();
    for (int i = 0; i < 7; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= regs[i];
      cfg_data <= CFG_W'(vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;

    for (int k = 0; k < n; k++) begin
      if (src_gaps && $urandom_range(0, 4) == 0) begin
        pix_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end else if (src_gaps && $urandom_range(0, 63) == 0) begin
        // hold until the block has delivered everything
        pix_ch.valid <= 1'b0;
        do @(negedge clk); while (rects_pending != 0);
      end
      pix_ch.valid <= 1'b1;
      pix_ch.pixel <= patterned ? ramp[k % 4] : GREY_W'($urandom_range(0, 255));
      @(posedge clk);
      while (!pix_ch.ready) @(posedge clk);
      @(negedge clk);
    end
    pix_ch.valid <= 1'b0;
    pixels_sent += n;
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_START_COL;
    cfg_data      = '0;
    pix_ch.valid  = 1'b0;
    pix_ch.pixel  = '0;
    src_gaps      = 1'b1;
    sink_stalls   = 1'b1;
    pixels_sent   = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // small directed frames
    run_frame(0, 0, 8'hFF, ROW_AUTO, 1, 3, 2, 1);
    run_frame(0, 0, 8'h00, ROW_FULL, 0, 2, 3, 1);
    run_frame(10, 0, 8'hA5, ROW_SPARE, 1, 3, 2, 1);
    run_frame(0, 4095, 8'h3C, ROW_HALF, 1, 0, 0, 1);
    run_frame(0, 0, 8'hFF, ROW_AUTO, 0, 2, 1, 1);

    // offset extremes and clamped fills
    run_frame(0, 0, 8'hFF, ROW_FULL, 1, 24, 1, 0);
    run_frame(4095, 0, 8'h00, ROW_AUTO, 1, 24, 1, 0);
    run_frame(0, 0, 8'h81, ROW_AUTO, 0, 1, 24, 0);
    run_frame(5, 1, 8'h7E, ROW_AUTO, 0, 20, 3, 0);

    // random small frames, no idling toward the end
    pixels_sent = 0;
    while (pixels_sent < 150) begin
      src_gaps    = ($urandom_range(0, 3) != 0) && (pixels_sent < 100);
      sink_stalls = ($urandom_range(0, 3) != 0) && (pixels_sent < 100);
      run_frame(pick_offset(), pick_offset(), $urandom_range(0, 255),
                $urandom_range(0, 3), $urandom_range(0, 1),
                $urandom_range(1, 12), $urandom_range(1, 10), 0);
    end

    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    while (rects_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[raster_crop_pad_window_unit.f]
rtl/rcp_pkg.sv
rtl/rcp_pix_if.sv
rtl/rcp_res_if.sv
rtl/raster_crop_pad_window_unit.sv
rtl/rcp_port_checker.sv
tb/rcp_window_checker.sv
tb/tb_raster_crop_pad_window_unit.sv
